// ===== hdl/sgmpca_pkg.sv =====
// Shared types and constants for the SGM path cost aggregation unit.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package sgmpca_pkg;

   // Storage geometry.
   localparam int MAX_DISP   = 64;
   localparam int DISP_W     = $clog2(MAX_DISP);
   localparam int NUM_DISP_W = 7;
   localparam int CMP_W      = (DISP_W + 1 > NUM_DISP_W) ? DISP_W + 1 : NUM_DISP_W;

   // Field widths.
   localparam int MATCH_W   = 8;
   localparam int PENALTY_W = 14;
   localparam int COST_W    = 15;
   localparam int P1_W      = 8;
   localparam int CSR_W     = 8;

   // Cost constants.
   localparam logic [COST_W-1:0] OUT_OF_RANGE_COST = COST_W'(255 * 64);
   localparam logic [COST_W-1:0] SUM_LIMIT         = COST_W'(32767);
   localparam logic [COST_W-1:0] MIN_ALL_ONES      = '1;

   // Register reset values.
   localparam logic [P1_W-1:0]       SMALL_PENALTY_RST = P1_W'(8);
   localparam logic [NUM_DISP_W-1:0] NUM_DISP_RST      = NUM_DISP_W'(64);

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      CSR_SMALL_PENALTY   = 1'b0,
      CSR_NUM_DISPARITIES = 1'b1
   } csr_index_type;

   // One item held in the request register.
   typedef struct packed {
      logic [MATCH_W-1:0]   match_cost;
      logic [PENALTY_W-1:0] large_penalty;
      logic [COST_W-1:0]    prior_sum;
      logic                 path_start;
      logic                 first;
      logic                 last;
      logic [DISP_W-1:0]    disp;
   } item_type;

   // Old path costs read for one item: its own disparity and the next one.
   typedef struct packed {
      logic [COST_W-1:0] old_cost;
      logic [COST_W-1:0] right_cost;
   } store_rd_type;

endpackage

`default_nettype wire

// ===== hdl/sgm_path_cost_aggregation_unit.sv =====
// SGM path cost aggregation along one scan direction. The unit takes one
// disparity element per cycle while req_ready is high, disparities ascending
// within each pixel, and offers one result per element on the result channel
// from the result register: the cost memory is read at the transfer edge,
// alongside the request register, and the recurrence runs in one pass between
// the request register and the result register. The previous pixel's costs
// sit in a 64-entry memory read at the current and next disparity; per-entry
// valid bits stand for its zero reset, so no clearing pass is needed and
// elements are taken from the first cycle after reset. A stalled result holds
// one more element in the request register before the request side stalls.
// Pixel boundaries come from an internal disparity counter alone.
// Depends on sgmpca_pkg, sgmpca_cost_store and sgmpca_cost_update.
`default_nettype none

module sgm_path_cost_aggregation_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration writes.
   input  wire logic                                  csr_wr_en,
   input  wire logic [0:0]                            csr_index,
   input  wire logic [sgmpca_pkg::CSR_W-1:0]          csr_wr_data,
   // Request channel.
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [sgmpca_pkg::MATCH_W-1:0]        req_match_cost,
   input  wire logic [sgmpca_pkg::PENALTY_W-1:0]      req_large_penalty,
   input  wire logic [sgmpca_pkg::COST_W-1:0]         req_prior_sum,
   input  wire logic                                  req_path_start,
   // Result channel.
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [sgmpca_pkg::COST_W-1:0]         rsp_path_cost,
   output logic      [sgmpca_pkg::COST_W-1:0]         rsp_new_sum,
   output logic                                       rsp_last_of_pixel
);

   localparam int CW = sgmpca_pkg::CMP_W;
   localparam int DW = sgmpca_pkg::DISP_W;

   // Configuration registers.
   logic [sgmpca_pkg::P1_W-1:0]       small_penalty_ff;
   logic [sgmpca_pkg::NUM_DISP_W-1:0] num_disp_ff;

   // Request side.
   logic [DW-1:0]                     cnt_ff;
   logic [DW-1:0]                     cnt_in;
   logic [CW-1:0]                     n_eff;
   logic [DW-1:0]                     disp;
   logic                              last;
   logic                              req_xfer;

   // Compute stage.
   logic                              s1_valid_ff;
   sgmpca_pkg::item_type              s1_item_ff;
   sgmpca_pkg::item_type              s1_item_in;
   logic [sgmpca_pkg::COST_W-1:0]     s1_held_ff;
   logic                              s1_fire;
   sgmpca_pkg::store_rd_type          store_rd;
   logic [sgmpca_pkg::COST_W-1:0]     cost;
   logic [sgmpca_pkg::COST_W-1:0]     sum;

   // Pixel minima.
   logic [sgmpca_pkg::COST_W-1:0]     prev_min_ff;
   logic [sgmpca_pkg::COST_W-1:0]     run_min_ff;
   logic [sgmpca_pkg::COST_W-1:0]     run_min_in;

   // Result register.
   logic                              rsp_valid_ff;
   logic [sgmpca_pkg::COST_W-1:0]     rsp_path_cost_ff;
   logic [sgmpca_pkg::COST_W-1:0]     rsp_new_sum_ff;
   logic                              rsp_last_ff;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         small_penalty_ff <= sgmpca_pkg::SMALL_PENALTY_RST;
         num_disp_ff      <= sgmpca_pkg::NUM_DISP_RST;
      end else if (csr_wr_en) begin
         case (sgmpca_pkg::csr_index_type'(csr_index))
            sgmpca_pkg::CSR_SMALL_PENALTY: begin
               small_penalty_ff <= csr_wr_data[sgmpca_pkg::P1_W-1:0];
            end
            sgmpca_pkg::CSR_NUM_DISPARITIES: begin
               num_disp_ff <= csr_wr_data[sgmpca_pkg::NUM_DISP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Disparity count in use, clamped to one through the memory depth.
   always_comb begin
      if (num_disp_ff == '0) begin
         n_eff = CW'(1);
      end else if (CW'(num_disp_ff) > CW'(sgmpca_pkg::MAX_DISP)) begin
         n_eff = CW'(sgmpca_pkg::MAX_DISP);
      end else begin
         n_eff = CW'(num_disp_ff);
      end
   end

   // Disparity of the next transfer; a counter past the count means last.
   always_comb begin
      if (CW'(cnt_ff) >= n_eff) begin
         disp = DW'(n_eff - CW'(1));
      end else begin
         disp = cnt_ff;
      end
      last   = (CW'(disp) + CW'(1)) >= n_eff;
      cnt_in = last ? '0 : disp + DW'(1);
   end

   // Handshake: the compute stage frees up whenever the result can move.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_item_in.match_cost    = req_match_cost;
      s1_item_in.large_penalty = req_large_penalty;
      s1_item_in.prior_sum     = req_prior_sum;
      s1_item_in.path_start    = req_path_start;
      s1_item_in.first         = (disp == '0);
      s1_item_in.last          = last;
      s1_item_in.disp          = disp;
   end

   // Request register and disparity counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
            cnt_ff      <= cnt_in;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // The held neighbor is the old cost read for the element before.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_held_ff <= '0;
      end else if (req_xfer) begin
         s1_held_ff <= store_rd.old_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // Previous pixel's costs, overwritten as the current pixel proceeds.
   sgmpca_cost_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_addr_c (disp),
      .rd_addr_r (disp + DW'(1)),
      .wr_en     (s1_fire),
      .wr_addr   (s1_item_ff.disp),
      .wr_data   (cost),
      .rd_data   (store_rd)
   );

   sgmpca_cost_update u_update (
      .item          (s1_item_ff),
      .prev          (store_rd),
      .held_cost     (s1_held_ff),
      .prev_min      (prev_min_ff),
      .small_penalty (small_penalty_ff),
      .path_cost     (cost),
      .new_sum       (sum)
   );

   // Minimum tracking across a pixel.
   assign run_min_in = (cost < run_min_ff) ? cost : run_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_min_ff <= '0;
         run_min_ff  <= sgmpca_pkg::MIN_ALL_ONES;
      end else if (s1_fire) begin
         if (s1_item_ff.last) begin
            prev_min_ff <= run_min_in;
            run_min_ff  <= sgmpca_pkg::MIN_ALL_ONES;
         end else begin
            run_min_ff <= run_min_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_path_cost_ff <= cost;
         rsp_new_sum_ff   <= sum;
         rsp_last_ff      <= s1_item_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_path_cost     = rsp_path_cost_ff;
   assign rsp_new_sum       = rsp_new_sum_ff;
   assign rsp_last_of_pixel = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/sgmpca_cost_store.sv =====
// Path cost memory of the previous pixel: one write port, two read ports,
// registered read data, per-entry valid bits and write-to-read bypass.
// Depends on sgmpca_pkg.
`default_nettype none

module sgmpca_cost_store (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rd_en,
   input  wire logic [sgmpca_pkg::DISP_W-1:0]     rd_addr_c,
   input  wire logic [sgmpca_pkg::DISP_W-1:0]     rd_addr_r,
   input  wire logic                              wr_en,
   input  wire logic [sgmpca_pkg::DISP_W-1:0]     wr_addr,
   input  wire logic [sgmpca_pkg::COST_W-1:0]     wr_data,
   output sgmpca_pkg::store_rd_type               rd_data
);

   logic [sgmpca_pkg::COST_W-1:0] mem_ff [sgmpca_pkg::MAX_DISP];
   logic                          vld_ff [sgmpca_pkg::MAX_DISP];

   logic [sgmpca_pkg::COST_W-1:0] old_rd_ff;
   logic [sgmpca_pkg::COST_W-1:0] right_rd_ff;
   logic [sgmpca_pkg::COST_W-1:0] old_byp_ff;
   logic [sgmpca_pkg::COST_W-1:0] right_byp_ff;
   logic                          old_vld_ff;
   logic                          right_vld_ff;
   logic                          old_hit_ff;
   logic                          right_hit_ff;

   logic old_hit_in;
   logic right_hit_in;

   // A write at the same edge as a read of the same entry is passed through.
   assign old_hit_in   = wr_en && (wr_addr == rd_addr_c);
   assign right_hit_in = wr_en && (wr_addr == rd_addr_r);

   // Memory array and read data registers.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         old_rd_ff    <= mem_ff[rd_addr_c];
         right_rd_ff  <= mem_ff[rd_addr_r];
         old_byp_ff   <= wr_data;
         right_byp_ff <= wr_data;
      end
   end

   // Valid bits stand for the all-zero reset contents of the memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sgmpca_pkg::MAX_DISP; i++) begin
            vld_ff[i] <= 1'b0;
         end
         old_vld_ff   <= 1'b0;
         right_vld_ff <= 1'b0;
         old_hit_ff   <= 1'b0;
         right_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            old_vld_ff   <= vld_ff[rd_addr_c];
            right_vld_ff <= vld_ff[rd_addr_r];
            old_hit_ff   <= old_hit_in;
            right_hit_ff <= right_hit_in;
         end
      end
   end

   // Resolve bypass and never-written entries.
   always_comb begin
      if (old_hit_ff) begin
         rd_data.old_cost = old_byp_ff;
      end else if (old_vld_ff) begin
         rd_data.old_cost = old_rd_ff;
      end else begin
         rd_data.old_cost = '0;
      end
      if (right_hit_ff) begin
         rd_data.right_cost = right_byp_ff;
      end else if (right_vld_ff) begin
         rd_data.right_cost = right_rd_ff;
      end else begin
         rd_data.right_cost = '0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sgmpca_cost_update.sv =====
// Path cost recurrence for one disparity: min-subtraction of the previous
// costs, the four-way minimum with P1 and P2, and the saturating sum.
// Depends on sgmpca_pkg.
`default_nettype none

module sgmpca_cost_update (
   input  wire sgmpca_pkg::item_type              item,
   input  wire sgmpca_pkg::store_rd_type          prev,
   input  wire logic [sgmpca_pkg::COST_W-1:0]     held_cost,
   input  wire logic [sgmpca_pkg::COST_W-1:0]     prev_min,
   input  wire logic [sgmpca_pkg::P1_W-1:0]       small_penalty,
   output logic      [sgmpca_pkg::COST_W-1:0]     path_cost,
   output logic      [sgmpca_pkg::COST_W-1:0]     new_sum
);

   localparam int W = sgmpca_pkg::COST_W + 1;

   logic [sgmpca_pkg::COST_W-1:0] rel_c;
   logic [sgmpca_pkg::COST_W-1:0] rel_l;
   logic [sgmpca_pkg::COST_W-1:0] rel_r;
   logic [sgmpca_pkg::COST_W-1:0] left_v;
   logic [sgmpca_pkg::COST_W-1:0] right_v;
   logic [sgmpca_pkg::COST_W-1:0] centre_v;
   logic [W-1:0]                  left_p;
   logic [W-1:0]                  right_p;
   logic [W-1:0]                  min_lr;
   logic [W-1:0]                  min_cp;
   logic [W-1:0]                  best;
   logic [W-1:0]                  cost_full;
   logic [W-1:0]                  sum_full;

   // Costs relative to the previous pixel's minimum, floored at zero.
   function automatic logic [sgmpca_pkg::COST_W-1:0] rel_cost(
      input logic [sgmpca_pkg::COST_W-1:0] v,
      input logic [sgmpca_pkg::COST_W-1:0] m
   );
      rel_cost = (v >= m) ? v - m : '0;
   endfunction

   always_comb begin
      rel_c = rel_cost(prev.old_cost, prev_min);
      rel_l = rel_cost(held_cost, prev_min);
      rel_r = rel_cost(prev.right_cost, prev_min);

      // At a path start all in-range previous costs count as zero.
      centre_v = item.path_start ? '0 : rel_c;
      if (item.first) begin
         left_v = sgmpca_pkg::OUT_OF_RANGE_COST;
      end else begin
         left_v = item.path_start ? '0 : rel_l;
      end
      if (item.last) begin
         right_v = sgmpca_pkg::OUT_OF_RANGE_COST;
      end else begin
         right_v = item.path_start ? '0 : rel_r;
      end

      // Four-way minimum.
      left_p  = W'(left_v) + W'(small_penalty);
      right_p = W'(right_v) + W'(small_penalty);
      min_lr  = (left_p < right_p) ? left_p : right_p;
      min_cp  = (W'(centre_v) < W'(item.large_penalty)) ?
                W'(centre_v) : W'(item.large_penalty);
      best    = (min_lr < min_cp) ? min_lr : min_cp;

      cost_full = best + W'(item.match_cost);
      path_cost = cost_full[sgmpca_pkg::COST_W-1:0];

      // Direction sum, saturated.
      sum_full = W'(item.prior_sum) + W'(path_cost);
      if (sum_full > W'(sgmpca_pkg::SUM_LIMIT)) begin
         new_sum = sgmpca_pkg::SUM_LIMIT;
      end else begin
         new_sum = sum_full[sgmpca_pkg::COST_W-1:0];
      end
   end

endmodule

`default_nettype wire
